// ===== sv/msah_pkg.sv =====
// package: opcodes, status codes, controller states and command/status bundles
`timescale 1ns / 1ps

package msah_pkg;

   // special-group function codes
   localparam logic [5:0] OP_SLL    = 6'd0;
   localparam logic [5:0] OP_SRL    = 6'd2;
   localparam logic [5:0] OP_SRA    = 6'd3;
   localparam logic [5:0] OP_SLLV   = 6'd4;
   localparam logic [5:0] OP_SRLV   = 6'd6;
   localparam logic [5:0] OP_SRAV   = 6'd7;
   localparam logic [5:0] OP_MFHI   = 6'd16;
   localparam logic [5:0] OP_MTHI   = 6'd17;
   localparam logic [5:0] OP_MFLO   = 6'd18;
   localparam logic [5:0] OP_MTLO   = 6'd19;
   localparam logic [5:0] OP_DSLLV  = 6'd20;
   localparam logic [5:0] OP_DSRLV  = 6'd22;
   localparam logic [5:0] OP_DSRAV  = 6'd23;
   localparam logic [5:0] OP_MULT   = 6'd24;
   localparam logic [5:0] OP_MULTU  = 6'd25;
   localparam logic [5:0] OP_DIV    = 6'd26;
   localparam logic [5:0] OP_DIVU   = 6'd27;
   localparam logic [5:0] OP_DMULT  = 6'd28;
   localparam logic [5:0] OP_DMULTU = 6'd29;
   localparam logic [5:0] OP_DDIV   = 6'd30;
   localparam logic [5:0] OP_DDIVU  = 6'd31;
   localparam logic [5:0] OP_ADD    = 6'd32;
   localparam logic [5:0] OP_ADDU   = 6'd33;
   localparam logic [5:0] OP_SUB    = 6'd34;
   localparam logic [5:0] OP_SUBU   = 6'd35;
   localparam logic [5:0] OP_AND    = 6'd36;
   localparam logic [5:0] OP_OR     = 6'd37;
   localparam logic [5:0] OP_XOR    = 6'd38;
   localparam logic [5:0] OP_NOR    = 6'd39;
   localparam logic [5:0] OP_SLT    = 6'd42;
   localparam logic [5:0] OP_SLTU   = 6'd43;
   localparam logic [5:0] OP_DADD   = 6'd44;
   localparam logic [5:0] OP_DADDU  = 6'd45;
   localparam logic [5:0] OP_DSUB   = 6'd46;
   localparam logic [5:0] OP_DSUBU  = 6'd47;
   localparam logic [5:0] OP_DSLL   = 6'd56;
   localparam logic [5:0] OP_DSRL   = 6'd58;
   localparam logic [5:0] OP_DSRA   = 6'd59;
   localparam logic [5:0] OP_DSLL32 = 6'd60;
   localparam logic [5:0] OP_DSRL32 = 6'd62;
   localparam logic [5:0] OP_DSRA32 = 6'd63;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIVZ = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // multiply partial products and divide iterations
   localparam logic [5:0] MUL_LAST = 6'd4;
   localparam logic [5:0] DIV_LAST = 6'd63;

   typedef enum logic [2:0] {
      KIND_ALU,
      KIND_MOVE,
      KIND_MUL,
      KIND_DIV,
      KIND_BAD
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_MUL_FIX,
      S_DIV,
      S_DIV_FIX,
      S_FIN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_step;
      logic       mul_acc;
      logic [1:0] mul_idx;
      logic       mul_fix;
      logic       div_step;
      logic       div_fix;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      kind_type req_kind;
      logic     req_div_zero;
   } stat_type;

   function automatic kind_type op_kind(input logic [5:0] op);
      kind_type k;
      case (op) inside
         OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_MFHI, OP_MFLO,
         OP_DSLLV, OP_DSRLV, OP_DSRAV, OP_ADD, OP_ADDU, OP_SUB, OP_SUBU,
         OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU, OP_DADD, OP_DADDU,
         OP_DSUB, OP_DSUBU, OP_DSLL, OP_DSRL, OP_DSRA, OP_DSLL32, OP_DSRL32,
         OP_DSRA32:                              k = KIND_ALU;
         OP_MTHI, OP_MTLO:                       k = KIND_MOVE;
         OP_MULT, OP_MULTU, OP_DMULT, OP_DMULTU: k = KIND_MUL;
         OP_DIV, OP_DIVU, OP_DDIV, OP_DDIVU:     k = KIND_DIV;
         default:                                k = KIND_BAD;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] sext32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

endpackage

// ===== sv/mips64_special_alu_hilo.sv =====
// top level: mips64 special-group execution unit with hi/lo
`timescale 1ns / 1ps
// usage
//   req_* channel: one beat per special-group instruction (function code,
//     rs and rt values, shift amount, destination index); taken at a rising
//     edge with req_valid high and req_stall low
//   rsp_* channel: one beat per instruction, in order; register write (only for
//     shifts, alu ops, mfhi and mflo, suppressed for destination zero) and a status code
//   steps from accept to rsp_valid:
//     shifts, alu, moves, unsupported codes and divide by zero: result push only
//     multiplies: four 32x32 partial products, then sign fix, then result push
//     divides: 64 restoring iterations, then sign fix, then result push
//   throughput: one instruction at a time; req_stall drops as the result
//     beat is loaded into the output register, so the next item
//     enters while the previous result still waits on rsp_stall
//   the divider loop makes divides the slowest kind of item
//   reset clears hi and lo to zero and empties the output register
//   when the receiver stalls, the result beat holds and a finished item
//   waits in its final state until the output register frees up

module mips64_special_alu_hilo (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_operation,
   input  logic [63:0] req_rs_value,
   input  logic [63:0] req_rt_value,
   input  logic [4:0]  req_shift_amount,
   input  logic [4:0]  req_dest_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_enable,
   output logic [4:0]  rsp_write_index,
   output logic [63:0] rsp_write_value,
   output logic [1:0]  rsp_status
);

   // command and status between controller and datapath
   msah_pkg::cmd_type  cmd;
   msah_pkg::stat_type stat;

   msah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   msah_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_rs_value     (req_rs_value),
      .req_rt_value     (req_rt_value),
      .req_shift_amount (req_shift_amount),
      .req_dest_index   (req_dest_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_write_enable (rsp_write_enable),
      .rsp_write_index  (rsp_write_index),
      .rsp_write_value  (rsp_write_value),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== sv/msah_ctrl.sv =====
// controller: sequences load, multiply steps, divide iterations and result push
`timescale 1ns / 1ps

module msah_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  msah_pkg::stat_type stat,
   output msah_pkg::cmd_type  cmd
);

   msah_pkg::state_type state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                push;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msah_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != msah_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign push      = (state_ff == msah_pkg::S_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = accept;
      cmd.mul_idx = cnt_ff[1:0];
      unique case (state_ff)
         msah_pkg::S_IDLE: begin
            if (accept) begin
               if (stat.req_kind == msah_pkg::KIND_MUL)
                  state_in = msah_pkg::S_MUL;
               else if (stat.req_kind == msah_pkg::KIND_DIV && !stat.req_div_zero)
                  state_in = msah_pkg::S_DIV;
               else
                  state_in = msah_pkg::S_FIN;
            end
         end
         msah_pkg::S_MUL: begin
            cmd.mul_step = (cnt_ff != msah_pkg::MUL_LAST);
            cmd.mul_acc  = (cnt_ff != '0);
            if (cnt_ff == msah_pkg::MUL_LAST) state_in = msah_pkg::S_MUL_FIX;
         end
         msah_pkg::S_MUL_FIX: begin
            cmd.mul_fix = 1'b1;
            state_in    = msah_pkg::S_FIN;
         end
         msah_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == msah_pkg::DIV_LAST) state_in = msah_pkg::S_DIV_FIX;
         end
         msah_pkg::S_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = msah_pkg::S_FIN;
         end
         msah_pkg::S_FIN: begin
            cmd.fin = push;
            if (push) state_in = msah_pkg::S_IDLE;
         end
         default: state_in = msah_pkg::S_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 6'd1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (push) rsp_valid_in = 1'b1;
   end

endmodule

// ===== sv/msah_dp.sv =====
// datapath: operand latches, shifter/alu, multiplier, divider, hi/lo, result register
`timescale 1ns / 1ps

module msah_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [5:0]         req_operation,
   input  logic [63:0]        req_rs_value,
   input  logic [63:0]        req_rt_value,
   input  logic [4:0]         req_shift_amount,
   input  logic [4:0]         req_dest_index,
   input  msah_pkg::cmd_type  cmd,
   output msah_pkg::stat_type stat,
   output logic               rsp_write_enable,
   output logic [4:0]         rsp_write_index,
   output logic [63:0]        rsp_write_value,
   output logic [1:0]         rsp_status
);

   logic [5:0]   op_ff;
   logic [63:0]  rs_ff, rt_ff;
   logic [4:0]   sa_ff, dest_ff;
   logic         divz_ff;
   logic [63:0]  hi_ff, lo_ff;
   logic [63:0]  ma_ff, mb_ff, p_ff;
   logic [1:0]   pidx_ff;
   logic [127:0] acc_ff;
   logic [63:0]  q_ff, r_ff, d_ff;
   logic         negq_ff, negr_ff, half_ff;
   logic         we_ff;
   logic [4:0]   idx_ff;
   logic [63:0]  val_ff;
   logic [1:0]   st_ff;

   msah_pkg::kind_type kind;
   logic         req_div32, req_dsigned;
   logic [63:0]  dva, dvb;
   logic         na, nb;
   logic [63:0]  ma_in, mb_in;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_prod;
   logic [127:0] acc_add;
   logic [64:0]  trial;
   logic [63:0]  qv, rv, mhi;
   logic [5:0]   amt;
   logic [63:0]  sh_src, sh_l, sh_r, sh_a, alu_val;
   logic         sh32;

   // request side decode for the controller
   assign stat.req_kind     = msah_pkg::op_kind(req_operation);
   assign req_div32         = (req_operation == msah_pkg::OP_DIV) ||
                              (req_operation == msah_pkg::OP_DIVU);
   assign stat.req_div_zero = req_div32 ? (req_rt_value[31:0] == '0)
                                        : (req_rt_value == '0);
   assign req_dsigned       = (req_operation == msah_pkg::OP_DIV) ||
                              (req_operation == msah_pkg::OP_DDIV);

   always_comb begin
      dva = req_rs_value;
      dvb = req_rt_value;
      if (req_operation == msah_pkg::OP_DIV) begin
         dva = msah_pkg::sext32(req_rs_value[31:0]);
         dvb = msah_pkg::sext32(req_rt_value[31:0]);
      end else if (req_operation == msah_pkg::OP_DIVU) begin
         dva = {32'b0, req_rs_value[31:0]};
         dvb = {32'b0, req_rt_value[31:0]};
      end
      na = req_dsigned && dva[63];
      nb = req_dsigned && dvb[63];
      ma_in = req_rs_value;
      mb_in = req_rt_value;
      if (req_operation == msah_pkg::OP_MULT) begin
         ma_in = msah_pkg::sext32(req_rs_value[31:0]);
         mb_in = msah_pkg::sext32(req_rt_value[31:0]);
      end else if (req_operation == msah_pkg::OP_MULTU) begin
         ma_in = {32'b0, req_rs_value[31:0]};
         mb_in = {32'b0, req_rt_value[31:0]};
      end
   end

   // multiplier: one 32x32 partial product per step
   assign mul_a    = cmd.mul_idx[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign mul_b    = cmd.mul_idx[1] ? mb_ff[63:32] : mb_ff[31:0];
   assign mul_prod = mul_a * mul_b;

   always_comb begin
      case (pidx_ff)
         2'd0:    acc_add = {64'b0, p_ff};
         2'd3:    acc_add = {p_ff, 64'b0};
         default: acc_add = {32'b0, p_ff, 32'b0};
      endcase
      mhi = acc_ff[127:64] - (ma_ff[63] ? mb_ff : 64'b0) - (mb_ff[63] ? ma_ff : 64'b0);
   end

   // divider: restoring, one quotient bit per step
   assign trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
   assign qv    = negq_ff ? (64'b0 - q_ff) : q_ff;
   assign rv    = negr_ff ? (64'b0 - r_ff) : r_ff;

   // shifter and alu on latched operands
   always_comb begin
      amt  = {1'b0, sa_ff};
      sh32 = 1'b0;
      unique case (op_ff)
         msah_pkg::OP_SLL, msah_pkg::OP_SRL, msah_pkg::OP_SRA: sh32 = 1'b1;
         msah_pkg::OP_SLLV, msah_pkg::OP_SRLV, msah_pkg::OP_SRAV: begin
            sh32 = 1'b1;
            amt  = {1'b0, rs_ff[4:0]};
         end
         msah_pkg::OP_DSLLV, msah_pkg::OP_DSRLV, msah_pkg::OP_DSRAV: amt = rs_ff[5:0];
         msah_pkg::OP_DSLL32, msah_pkg::OP_DSRL32, msah_pkg::OP_DSRA32:
            amt = {1'b1, sa_ff};
         default: amt = {1'b0, sa_ff};
      endcase
      sh_src = sh32 ? msah_pkg::sext32(rt_ff[31:0]) : rt_ff;
      if (sh32 && (op_ff == msah_pkg::OP_SRL || op_ff == msah_pkg::OP_SRLV))
         sh_src = {32'b0, rt_ff[31:0]};
      sh_l = sh_src << amt;
      sh_r = sh_src >> amt;
      sh_a = 64'($signed(sh_src) >>> amt);

      unique case (op_ff)
         msah_pkg::OP_SLL, msah_pkg::OP_SLLV:    alu_val = msah_pkg::sext32(sh_l[31:0]);
         msah_pkg::OP_SRL, msah_pkg::OP_SRLV:    alu_val = msah_pkg::sext32(sh_r[31:0]);
         msah_pkg::OP_SRA, msah_pkg::OP_SRAV:    alu_val = msah_pkg::sext32(sh_a[31:0]);
         msah_pkg::OP_DSLLV, msah_pkg::OP_DSLL,
         msah_pkg::OP_DSLL32:                    alu_val = sh_l;
         msah_pkg::OP_DSRLV, msah_pkg::OP_DSRL,
         msah_pkg::OP_DSRL32:                    alu_val = sh_r;
         msah_pkg::OP_DSRAV, msah_pkg::OP_DSRA,
         msah_pkg::OP_DSRA32:                    alu_val = sh_a;
         msah_pkg::OP_MFHI:                      alu_val = hi_ff;
         msah_pkg::OP_MFLO:                      alu_val = lo_ff;
         msah_pkg::OP_ADD, msah_pkg::OP_ADDU:
            alu_val = msah_pkg::sext32(rs_ff[31:0] + rt_ff[31:0]);
         msah_pkg::OP_SUB, msah_pkg::OP_SUBU:
            alu_val = msah_pkg::sext32(rs_ff[31:0] - rt_ff[31:0]);
         msah_pkg::OP_AND:                       alu_val = rs_ff & rt_ff;
         msah_pkg::OP_OR:                        alu_val = rs_ff | rt_ff;
         msah_pkg::OP_XOR:                       alu_val = rs_ff ^ rt_ff;
         msah_pkg::OP_NOR:                       alu_val = ~(rs_ff | rt_ff);
         msah_pkg::OP_SLT:
            alu_val = {63'b0, ($signed(rs_ff) < $signed(rt_ff))};
         msah_pkg::OP_SLTU:                      alu_val = {63'b0, (rs_ff < rt_ff)};
         msah_pkg::OP_DADD, msah_pkg::OP_DADDU:  alu_val = rs_ff + rt_ff;
         msah_pkg::OP_DSUB, msah_pkg::OP_DSUBU:  alu_val = rs_ff - rt_ff;
         default:                                alu_val = '0;
      endcase
   end

   assign kind = msah_pkg::op_kind(op_ff);

   // operand, multiply and divide registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         rs_ff   <= req_rs_value;
         rt_ff   <= req_rt_value;
         sa_ff   <= req_shift_amount;
         dest_ff <= req_dest_index;
         divz_ff <= stat.req_div_zero;
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         acc_ff  <= '0;
         q_ff    <= na ? (64'b0 - dva) : dva;
         d_ff    <= nb ? (64'b0 - dvb) : dvb;
         r_ff    <= '0;
         negq_ff <= na ^ nb;
         negr_ff <= na;
         half_ff <= req_div32;
      end else begin
         if (cmd.mul_acc) acc_ff <= acc_ff + acc_add;
         if (cmd.div_step) begin
            if (!trial[64]) begin
               r_ff <= trial[63:0];
               q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               r_ff <= {r_ff[62:0], q_ff[63]};
               q_ff <= {q_ff[62:0], 1'b0};
            end
         end
      end
      if (cmd.mul_step) begin
         p_ff    <= mul_prod;
         pidx_ff <= cmd.mul_idx;
      end
   end

   // hi/lo
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (cmd.mul_fix) begin
         if (op_ff == msah_pkg::OP_DMULT) begin
            hi_ff <= mhi;
            lo_ff <= acc_ff[63:0];
         end else if (op_ff == msah_pkg::OP_DMULTU) begin
            hi_ff <= acc_ff[127:64];
            lo_ff <= acc_ff[63:0];
         end else begin
            hi_ff <= msah_pkg::sext32(acc_ff[63:32]);
            lo_ff <= msah_pkg::sext32(acc_ff[31:0]);
         end
      end else if (cmd.div_fix) begin
         hi_ff <= half_ff ? msah_pkg::sext32(rv[31:0]) : rv;
         lo_ff <= half_ff ? msah_pkg::sext32(qv[31:0]) : qv;
      end else if (cmd.fin && op_ff == msah_pkg::OP_MTHI) begin
         hi_ff <= rs_ff;
      end else if (cmd.fin && op_ff == msah_pkg::OP_MTLO) begin
         lo_ff <= rs_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         we_ff  <= (kind == msah_pkg::KIND_ALU) && (dest_ff != '0);
         idx_ff <= dest_ff;
         val_ff <= ((kind == msah_pkg::KIND_ALU) && (dest_ff != '0)) ? alu_val : '0;
         if (kind == msah_pkg::KIND_BAD)
            st_ff <= msah_pkg::ST_BAD;
         else if (kind == msah_pkg::KIND_DIV && divz_ff)
            st_ff <= msah_pkg::ST_DIVZ;
         else
            st_ff <= msah_pkg::ST_OK;
      end
   end

   assign rsp_write_enable = we_ff;
   assign rsp_write_index  = idx_ff;
   assign rsp_write_value  = val_ff;
   assign rsp_status       = st_ff;

endmodule
